[rtl/set_assoc_cache_lru_fifo_macros.svh]
// Assertion macros shared by the checker of the set-associative cache.
`ifndef SET_ASSOC_CACHE_LRU_FIFO_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_FIFO_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sacl_pkg.sv]
// Shared constants, codes and types of the set-associative cache.
package sacl_pkg;

    // Default geometry; a line holds 16 bytes.
    localparam int DEF_MAX_SETS    = 1024;
    localparam int DEF_MAX_WAYS    = 8;
    localparam int DEF_ADDR_WIDTH  = 32;
    localparam int DEF_OFFSET_BITS = 4;

    localparam int COUNT_W    = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

    // Replacement policies.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Opcodes.
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration reset values.
    localparam logic                  POLICY_RESET   = POLICY_LRU;
    localparam logic [CFG_DATA_W-1:0] SET_BITS_RESET = 4'd10;
    localparam logic [CFG_DATA_W-1:0] WAYS_RESET     = 4'd1;

    // Result item layout in m_tdata.
    localparam int OUT_HIT_BIT   = 0;
    localparam int OUT_WAY_LSB   = 1;
    localparam int OUT_EVICT_BIT = OUT_WAY_LSB + WAY_OUT_W;
    localparam int OUT_ACC_LSB   = OUT_EVICT_BIT + 1;
    localparam int OUT_MISS_LSB  = OUT_ACC_LSB + COUNT_W;
    localparam int OUT_FIELDS_W  = OUT_MISS_LSB + COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic hit;
        logic have_free;
    } scan_flags_t;

endpackage

[rtl/set_assoc_cache_lru_fifo.sv]
// Set-associative tag cache with LRU or FIFO replacement: sequencer, set memory and counters.
// Each access item carries a byte address and returns one result item with hit, way,
// evicted and the saturating access and miss counts; a clear item invalidates every line,
// zeroes both counts and returns an all-zero result. An access keeps the block busy through
// one read of the set's row from the set memory, a pass over each way in use through the
// shared way compare unit, one write-back of tags, ranks and valid bits, and the hand-over
// of the result to the output register, which waits while that register is stalled. A clear
// sweeps the valid bits one set per cycle, as does the pass that follows reset; no item is
// accepted during either.
// Configuration writes are taken at any time but belong between items.
module set_assoc_cache_lru_fifo #(
    parameter int MAX_SETS    = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH  = sacl_pkg::DEF_ADDR_WIDTH,
    parameter int OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS,
    localparam int IN_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_TDATA_W-1:0]               s_tdata,   // address
    input  logic                                s_tuser,   // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, way, evicted, access_count, miss_count
    output logic [sacl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SET_AW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_IDX_BITS = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int TAG_W        = (ADDR_WIDTH > OFFSET_BITS) ? ADDR_WIDTH - OFFSET_BITS : 1;
    localparam int COUNT_W      = sacl_pkg::COUNT_W;
    localparam int PAD_W        = sacl_pkg::OUT_TDATA_W - sacl_pkg::OUT_FIELDS_W;
    localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(MAX_SETS - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef logic [MAX_WAYS-1:0]            valid_row_t;
    typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [MAX_WAYS-1:0][WAY_W-1:0] rank_row_t;

    // Set memory: one row per set, all ways side by side.
    valid_row_t valid_mem [MAX_SETS];
    tag_row_t   tag_mem   [MAX_SETS];
    rank_row_t  rec_mem   [MAX_SETS];
    rank_row_t  fill_mem  [MAX_SETS];

    state_t                        state_reg;
    state_t                        state_next;
    logic                          policy_reg;
    logic [sacl_pkg::CFG_DATA_W-1:0] idx_bits_reg;
    logic [sacl_pkg::CFG_DATA_W-1:0] ways_reg;
    logic [SET_AW-1:0]             sweep_reg;
    logic [WAY_W-1:0]              scan_reg;
    logic                          clr_out_reg;
    logic [COUNT_W-1:0]            acc_reg;
    logic [COUNT_W-1:0]            miss_reg;
    logic                          out_valid_reg;
    logic [sacl_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [SET_AW-1:0]             set_reg;
    logic [TAG_W-1:0]              tag_reg;
    logic                          res_hit_reg;
    logic [sacl_pkg::WAY_OUT_W-1:0] res_way_reg;
    logic                          res_evict_reg;
    valid_row_t                    rd_valid_reg;
    tag_row_t                      rd_tag_reg;
    rank_row_t                     rd_rec_reg;
    rank_row_t                     rd_fill_reg;

    logic [sacl_pkg::CFG_DATA_W-1:0] bits_eff;
    logic [WAY_CNT_W-1:0]          ways_eff;
    logic [WAY_W-1:0]              last_way;
    logic [ADDR_WIDTH-1:0]         addr_sh;
    logic [SET_AW-1:0]             key_set;
    logic [TAG_W-1:0]              key_tag;
    logic                          in_accept;
    logic                          out_load;
    logic [WAY_W-1:0]              line_rank;
    sacl_pkg::scan_flags_t         scan_flags;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              free_way;
    logic [WAY_W-1:0]              victim_way;
    logic [WAY_W-1:0]              found;
    logic                          was_valid;
    rank_row_t                     rec_new;
    rank_row_t                     fill_new;
    valid_row_t                    wr_valid;
    tag_row_t                      wr_tag;
    rank_row_t                     wr_fill;
    logic [COUNT_W-1:0]            acc_inc;
    logic [COUNT_W-1:0]            miss_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Effective geometry after clamping the configuration.
    always_comb
    begin
        if (int'(idx_bits_reg) > MAX_IDX_BITS)
        begin
            bits_eff = sacl_pkg::CFG_DATA_W'(MAX_IDX_BITS);
        end
        else
        begin
            bits_eff = idx_bits_reg;
        end
        if (ways_reg == '0)
        begin
            ways_eff = WAY_CNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAY_CNT_W'(ways_reg);
        end
    end

    assign last_way = WAY_W'(ways_eff - WAY_CNT_W'(1));
    assign addr_sh  = s_tdata[ADDR_WIDTH-1:0] >> OFFSET_BITS;
    assign key_set  = SET_AW'(addr_sh) & ~({SET_AW{1'b1}} << bits_eff);
    assign key_tag  = TAG_W'(addr_sh >> bits_eff);

    assign line_rank = (policy_reg == sacl_pkg::POLICY_LRU) ? rd_rec_reg[scan_reg]
                                                             : rd_fill_reg[scan_reg];

    sacl_way_scan #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W)
    ) u_way_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (state_reg == ST_SCAN),
        .first      (scan_reg == '0),
        .way_idx    (scan_reg),
        .line_valid (rd_valid_reg[scan_reg]),
        .line_tag   (rd_tag_reg[scan_reg]),
        .line_rank  (line_rank),
        .key_tag    (tag_reg),
        .flags      (scan_flags),
        .hit_way    (hit_way),
        .free_way   (free_way),
        .victim_way (victim_way)
    );

    always_comb
    begin
        if (scan_flags.hit)
        begin
            found = hit_way;
        end
        else if (scan_flags.have_free)
        begin
            found = free_way;
        end
        else
        begin
            found = victim_way;
        end
    end

    assign was_valid = scan_flags.hit || !scan_flags.have_free;

    sacl_rank_promote #(
        .MAX_WAYS (MAX_WAYS)
    ) u_rec_promote (
        .line_valid (rd_valid_reg),
        .rank_in    (rd_rec_reg),
        .target     (found),
        .was_valid  (was_valid),
        .rank_out   (rec_new)
    );

    sacl_rank_promote #(
        .MAX_WAYS (MAX_WAYS)
    ) u_fill_promote (
        .line_valid (rd_valid_reg),
        .rank_in    (rd_fill_reg),
        .target     (found),
        .was_valid  (was_valid),
        .rank_out   (fill_new)
    );

    // A miss installs the tag in the chosen way; a hit leaves tags and fill order alone.
    always_comb
    begin
        wr_valid = rd_valid_reg;
        wr_tag   = rd_tag_reg;
        wr_fill  = rd_fill_reg;
        if (!scan_flags.hit)
        begin
            wr_valid[found] = 1'b1;
            wr_tag[found]   = tag_reg;
            wr_fill         = fill_new;
        end
    end

    assign acc_inc  = (acc_reg == '1) ? acc_reg : acc_reg + COUNT_W'(1);
    assign miss_inc = (miss_reg == '1) ? miss_reg : miss_reg + COUNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_reg == LAST_SET)
                begin
                    state_next = clr_out_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == sacl_pkg::OP_CLEAR) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_reg == last_way)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            policy_reg    <= sacl_pkg::POLICY_RESET;
            idx_bits_reg  <= sacl_pkg::SET_BITS_RESET;
            ways_reg      <= sacl_pkg::WAYS_RESET;
            sweep_reg     <= '0;
            scan_reg      <= '0;
            clr_out_reg   <= 1'b0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sacl_pkg::CFG_POLICY:   policy_reg   <= cfg_data[0];
                    sacl_pkg::CFG_SET_BITS: idx_bits_reg <= cfg_data;
                    sacl_pkg::CFG_WAYS:     ways_reg     <= cfg_data;
                    default:                ;
                endcase
            end

            if (state_reg == ST_CLEAR)
            begin
                if (sweep_reg == LAST_SET)
                begin
                    sweep_reg   <= '0;
                    clr_out_reg <= 1'b0;
                end
                else
                begin
                    sweep_reg <= sweep_reg + SET_AW'(1);
                end
            end

            if (state_reg == ST_SCAN)
            begin
                scan_reg <= (scan_reg == last_way) ? '0 : scan_reg + WAY_W'(1);
            end

            if (in_accept && (s_tuser == sacl_pkg::OP_CLEAR))
            begin
                clr_out_reg <= 1'b1;
                acc_reg     <= '0;
                miss_reg    <= '0;
            end

            if (state_reg == ST_WRITE)
            begin
                acc_reg <= acc_inc;
                if (!scan_flags.hit)
                begin
                    miss_reg <= miss_inc;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            set_reg       <= key_set;
            tag_reg       <= key_tag;
            res_hit_reg   <= 1'b0;
            res_way_reg   <= '0;
            res_evict_reg <= 1'b0;
        end
        if (state_reg == ST_WRITE)
        begin
            res_hit_reg   <= scan_flags.hit;
            res_way_reg   <= sacl_pkg::WAY_OUT_W'(found);
            res_evict_reg <= !scan_flags.hit && !scan_flags.have_free;
        end
        if (out_load)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, miss_reg, acc_reg, res_evict_reg,
                             res_way_reg, res_hit_reg};
        end
    end

    // Valid bits are swept to zero by the clear pass; tags and ranks are only rewritten.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            valid_mem[sweep_reg] <= '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            valid_mem[set_reg] <= wr_valid;
        end
        if (state_reg == ST_READ)
        begin
            rd_valid_reg <= valid_mem[set_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            tag_mem[set_reg]  <= wr_tag;
            rec_mem[set_reg]  <= rec_new;
            fill_mem[set_reg] <= wr_fill;
        end
        if (state_reg == ST_READ)
        begin
            rd_tag_reg  <= tag_mem[set_reg];
            rd_rec_reg  <= rec_mem[set_reg];
            rd_fill_reg <= fill_mem[set_reg];
        end
    end

endmodule

[rtl/sacl_way_scan.sv]
// Shared way compare unit: looks at one way per cycle and tracks hit, free way and victim.
module sacl_way_scan #(
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
    parameter int TAG_W    = sacl_pkg::DEF_ADDR_WIDTH - sacl_pkg::DEF_OFFSET_BITS,
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  first,
    input  logic [WAY_W-1:0]      way_idx,
    input  logic                  line_valid,
    input  logic [TAG_W-1:0]      line_tag,
    input  logic [WAY_W-1:0]      line_rank,
    input  logic [TAG_W-1:0]      key_tag,
    output sacl_pkg::scan_flags_t flags,
    output logic [WAY_W-1:0]      hit_way,
    output logic [WAY_W-1:0]      free_way,
    output logic [WAY_W-1:0]      victim_way
);

    sacl_pkg::scan_flags_t flags_reg;
    logic [WAY_W-1:0]      hit_way_reg;
    logic [WAY_W-1:0]      free_way_reg;
    logic [WAY_W-1:0]      victim_way_reg;
    logic [WAY_W-1:0]      victim_rank_reg;
    logic                  match;

    assign match = line_valid && (line_tag == key_tag);

    // The lowest matching way hits and the lowest invalid way is the free one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (step)
        begin
            if (first)
            begin
                flags_reg.hit       <= match;
                flags_reg.have_free <= !line_valid;
            end
            else
            begin
                if (match)
                begin
                    flags_reg.hit <= 1'b1;
                end
                if (!line_valid)
                begin
                    flags_reg.have_free <= 1'b1;
                end
            end
        end
    end

    // Victim keeps the lowest way among those with the largest rank.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (first || (!flags_reg.hit && match))
            begin
                hit_way_reg <= way_idx;
            end
            if (first || (!flags_reg.have_free && !line_valid))
            begin
                free_way_reg <= way_idx;
            end
            if (first || (line_rank > victim_rank_reg))
            begin
                victim_way_reg  <= way_idx;
                victim_rank_reg <= line_rank;
            end
        end
    end

    assign flags      = flags_reg;
    assign hit_way    = hit_way_reg;
    assign free_way   = free_way_reg;
    assign victim_way = victim_way_reg;

endmodule

[rtl/sacl_rank_promote.sv]
// Moves one way of a set to rank zero and ages the other valid ways ranked ahead of it, or all of them for a new fill.
module sacl_rank_promote #(
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
    localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic [MAX_WAYS-1:0]             line_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_in,
    input  logic [RANK_W-1:0]               target,
    input  logic                            was_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0] rank_out
);

    logic [RANK_W-1:0] target_rank;

    assign target_rank = rank_in[target];

    // A newly filled way pushes every valid way down; a refreshed way only those above it.
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (RANK_W'(i) == target)
            begin
                rank_out[i] = '0;
            end
            else if (line_valid[i] && (!was_valid || (rank_in[i] < target_rank)))
            begin
                rank_out[i] = rank_in[i] + RANK_W'(1);
            end
            else
            begin
                rank_out[i] = rank_in[i];
            end
        end
    end

endmodule

[rtl/sacl_checker.sv]
// Port-level checker of the set-associative cache, bound to the top level.
`include "set_assoc_cache_lru_fifo_macros.svh"

module sacl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sacl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int HIT_BIT   = sacl_pkg::OUT_HIT_BIT;
    localparam int EVICT_BIT = sacl_pkg::OUT_EVICT_BIT;
    localparam int ACC_LO    = sacl_pkg::OUT_ACC_LSB;
    localparam int ACC_HI    = sacl_pkg::OUT_ACC_LSB + sacl_pkg::COUNT_W - 1;
    localparam int MISS_LO   = sacl_pkg::OUT_MISS_LSB;
    localparam int MISS_HI   = sacl_pkg::OUT_MISS_LSB + sacl_pkg::COUNT_W - 1;

    `SACL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed or dropped while stalled")

    `SACL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken again before the item was worked")

    `SACL_ASSERT_NOW(a_hit_no_evict, m_tvalid && m_tdata[HIT_BIT], !m_tdata[EVICT_BIT], "a hit reported an eviction")

    `SACL_ASSERT_NOW(a_miss_le_access, m_tvalid, m_tdata[MISS_HI:MISS_LO] <= m_tdata[ACC_HI:ACC_LO], "miss count above access count")

endmodule

bind set_assoc_cache_lru_fifo sacl_checker u_sacl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_set_assoc_cache_lru_fifo.sv]
// Self-checking testbench for the set-associative tag cache with LRU and FIFO replacement.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_fifo;

    localparam int DEF_MAX_SETS    = sacl_pkg::DEF_MAX_SETS;
    localparam int DEF_MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS;
    localparam int DEF_ADDR_WIDTH  = sacl_pkg::DEF_ADDR_WIDTH;
    localparam int DEF_OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS;
    localparam int WAY_OUT_W       = sacl_pkg::WAY_OUT_W;
    localparam int COUNT_W         = sacl_pkg::COUNT_W;
    localparam int CFG_IDX_W       = sacl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = sacl_pkg::CFG_DATA_W;
    localparam int OUT_TDATA_W     = sacl_pkg::OUT_TDATA_W;
    localparam int OUT_HIT_BIT     = sacl_pkg::OUT_HIT_BIT;
    localparam int OUT_WAY_LSB     = sacl_pkg::OUT_WAY_LSB;
    localparam int OUT_EVICT_BIT   = sacl_pkg::OUT_EVICT_BIT;
    localparam int OUT_ACC_LSB     = sacl_pkg::OUT_ACC_LSB;
    localparam int OUT_MISS_LSB    = sacl_pkg::OUT_MISS_LSB;

    localparam int LINES          = DEF_MAX_SETS * DEF_MAX_WAYS;
    localparam int INDEX_BITS_MAX = $clog2(DEF_MAX_SETS);
    localparam int TAG_W          = DEF_ADDR_WIDTH - DEF_OFFSET_BITS;
    localparam int HOT_TAGS       = DEF_MAX_WAYS + 3;

    typedef struct {
        bit                 hit;
        bit [WAY_OUT_W-1:0] way;
        bit                 evicted;
        bit [COUNT_W-1:0]   accesses;
        bit [COUNT_W-1:0]   misses;
    } cache_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [DEF_ADDR_WIDTH-1:0] s_tdata = '0;     // address
    logic                      s_tuser = sacl_pkg::OP_ACCESS; // opcode
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_tdata;          // hit, way, evicted, access_count, miss_count
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = sacl_pkg::CFG_POLICY;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Shadow copy of the cache used for prediction.
    logic                  pol_cfg      = sacl_pkg::POLICY_RESET;
    logic [CFG_DATA_W-1:0] set_bits_cfg = sacl_pkg::SET_BITS_RESET;
    logic [CFG_DATA_W-1:0] ways_cfg     = sacl_pkg::WAYS_RESET;
    bit [TAG_W-1:0]        line_tag [LINES];
    bit                    line_ok  [LINES];
    bit [2:0]              lru_rank [LINES];
    bit [2:0]              age_rank [LINES];
    bit [COUNT_W-1:0]      n_access = '0;
    bit [COUNT_W-1:0]      n_miss = '0;

    cache_result_t predicted_lookups[$];
    int            mismatch_count = 0;
    int unsigned   send_idle_pct = 17;
    int unsigned   recv_idle_pct = 58;
    logic          hold_rx = 1'b0;

    // Working set of lines that the random traffic keeps coming back to.
    int unsigned   hot_set [4];
    bit [31:0]     hot_tag [HOT_TAGS];
    int unsigned   n_hot_tags = 4;

    set_assoc_cache_lru_fifo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned index_bits_now();
        return (set_bits_cfg > INDEX_BITS_MAX) ? INDEX_BITS_MAX : set_bits_cfg;
    endfunction

    function automatic int unsigned ways_now();
        if (ways_cfg == 0)
            return 1;
        return (ways_cfg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_cfg;
    endfunction

    // Give way w rank 0 and age the other valid lines of the set behind it.
    function automatic void move_to_front(input bit fill_order, input int unsigned base,
                                          input int unsigned w, input bit was_valid);
        bit [2:0] old;
        bit [2:0] other;
        old = fill_order ? age_rank[base + w] : lru_rank[base + w];
        for (int unsigned i = 0; i < DEF_MAX_WAYS; i++)
        begin
            other = fill_order ? age_rank[base + i] : lru_rank[base + i];
            if (i != w && line_ok[base + i] && (!was_valid || other < old))
            begin
                if (fill_order)
                    age_rank[base + i] = other + 3'd1;
                else
                    lru_rank[base + i] = other + 3'd1;
            end
        end
        if (fill_order)
            age_rank[base + w] = '0;
        else
            lru_rank[base + w] = '0;
    endfunction

    function automatic cache_result_t predict_lookup(input logic op, input logic [31:0] addr);
        cache_result_t  res;
        int unsigned    eb;
        int unsigned    nw;
        int unsigned    base;
        int unsigned    pick;
        bit [TAG_W-1:0] tag;
        bit             found_hit;
        bit             found_free;
        bit             older;
        res = '{default: '0};
        if (op == sacl_pkg::OP_CLEAR)
        begin
            foreach (line_ok[i])
                line_ok[i] = 1'b0;
            n_access = '0;
            n_miss   = '0;
            return res;
        end
        eb   = index_bits_now();
        nw   = ways_now();
        base = ((addr >> DEF_OFFSET_BITS) & ((32'd1 << eb) - 1)) * DEF_MAX_WAYS;
        tag  = TAG_W'(addr >> (DEF_OFFSET_BITS + eb));
        found_hit  = 1'b0;
        found_free = 1'b0;
        pick       = 0;
        if (n_access != '1)
            n_access++;
        for (int unsigned w = 0; w < nw; w++)
            if (!found_hit && line_ok[base + w] && line_tag[base + w] == tag)
            begin
                found_hit = 1'b1;
                pick      = w;
            end
        if (found_hit)
            move_to_front(1'b0, base, pick, 1'b1);
        else
        begin
            if (n_miss != '1)
                n_miss++;
            for (int unsigned w = 0; w < nw; w++)
                if (!found_free && !line_ok[base + w])
                begin
                    found_free = 1'b1;
                    pick       = w;
                end
            if (found_free)
            begin
                move_to_front(1'b0, base, pick, 1'b0);
                move_to_front(1'b1, base, pick, 1'b0);
                line_ok[base + pick] = 1'b1;
            end
            else
            begin
                // Full set: the highest rank loses, the lowest way on a tie.
                for (int unsigned w = 1; w < nw; w++)
                begin
                    older = (pol_cfg == sacl_pkg::POLICY_LRU) ?
                            (lru_rank[base + w] > lru_rank[base + pick]) :
                            (age_rank[base + w] > age_rank[base + pick]);
                    if (older)
                        pick = w;
                end
                res.evicted = 1'b1;
                move_to_front(1'b0, base, pick, 1'b1);
                move_to_front(1'b1, base, pick, 1'b1);
            end
            line_tag[base + pick] = tag;
        end
        res.hit      = found_hit;
        res.way      = pick[WAY_OUT_W-1:0];
        res.accesses = n_access;
        res.misses   = n_miss;
        return res;
    endfunction

    function automatic void enqueue_lookup(input cache_result_t res);
        predicted_lookups.insert(predicted_lookups.size(), res);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        cache_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_lookups.size() == 0)
                report_mismatch("result item with no item outstanding");
            else
            begin
                want = predicted_lookups.pop_front();
                if (m_tdata[OUT_HIT_BIT] !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b",
                                              m_tdata[OUT_HIT_BIT], want.hit));
                if (m_tdata[OUT_WAY_LSB +: WAY_OUT_W] !== want.way)
                    report_mismatch($sformatf("way %0d, expected %0d",
                                              m_tdata[OUT_WAY_LSB +: WAY_OUT_W], want.way));
                if (m_tdata[OUT_EVICT_BIT] !== want.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b",
                                              m_tdata[OUT_EVICT_BIT], want.evicted));
                if (m_tdata[OUT_ACC_LSB +: COUNT_W] !== want.accesses)
                    report_mismatch($sformatf("access_count %0d, expected %0d",
                                              m_tdata[OUT_ACC_LSB +: COUNT_W], want.accesses));
                if (m_tdata[OUT_MISS_LSB +: COUNT_W] !== want.misses)
                    report_mismatch($sformatf("miss_count %0d, expected %0d",
                                              m_tdata[OUT_MISS_LSB +: COUNT_W], want.misses));
            end
        end
        m_tready <= rst_n && !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic push_item(input logic op, input logic [31:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        enqueue_lookup(predict_lookup(op, addr));
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (predicted_lookups.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Writes all three registers back to back; only call with the cache idle.
    task automatic apply_config(input logic pol, input logic [CFG_DATA_W-1:0] bits,
                                input logic [CFG_DATA_W-1:0] ways);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{sacl_pkg::CFG_POLICY, sacl_pkg::CFG_SET_BITS, sacl_pkg::CFG_WAYS};
        val = '{{3'b000, pol}, bits, ways};
        for (int r = 0; r < 3; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= val[r];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[r])
                sacl_pkg::CFG_POLICY:   pol_cfg      = val[r][0];
                sacl_pkg::CFG_SET_BITS: set_bits_cfg = val[r];
                sacl_pkg::CFG_WAYS:     ways_cfg     = val[r];
                default:                ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void setup_hot_lines();
        int unsigned eb;
        eb = index_bits_now();
        foreach (hot_set[i])
            hot_set[i] = $urandom() & ((32'd1 << eb) - 1);
        foreach (hot_tag[i])
            hot_tag[i] = $urandom();
        n_hot_tags = ways_now() + 3;
    endfunction

    function automatic logic [31:0] hot_address();
        int unsigned eb;
        logic [63:0] a;
        eb = index_bits_now();
        a  = (64'(hot_tag[$urandom_range(0, n_hot_tags - 1)]) << (DEF_OFFSET_BITS + eb))
           | (64'(hot_set[$urandom_range(0, 3)]) << DEF_OFFSET_BITS)
           | 64'($urandom_range(0, (1 << DEF_OFFSET_BITS) - 1));
        return a[31:0];
    endfunction

    // Reset values: LRU, ten index bits, one way.
    task automatic test_default_config();
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_0000);
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_000F);
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_4000);
        push_item(sacl_pkg::OP_ACCESS, 32'hFFFF_FFFF);
        push_item(sacl_pkg::OP_CLEAR,  32'hA5A5_A5A5);
        drain_results();
    endtask

    // One set of three ways: LRU victim first, then FIFO victim.
    task automatic test_replacement_order();
        apply_config(sacl_pkg::POLICY_LRU, 4'd0, 4'd3);
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_0000);
        push_item(sacl_pkg::OP_ACCESS, 32'hFFFF_FFF0);
        push_item(sacl_pkg::OP_ACCESS, 32'h1234_5670);
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_0008);
        push_item(sacl_pkg::OP_ACCESS, 32'h8000_0000);
        drain_results();
        apply_config(sacl_pkg::POLICY_FIFO, 4'd0, 4'd3);
        push_item(sacl_pkg::OP_ACCESS, 32'h7FFF_FFFF);
        drain_results();
    endtask

    // Shrinking the ways leaves lines behind; growing again finds duplicates.
    task automatic test_stale_ways();
        apply_config(sacl_pkg::POLICY_FIFO, 4'd0, 4'd1);
        push_item(sacl_pkg::OP_ACCESS, 32'h1234_5670);
        drain_results();
        apply_config(sacl_pkg::POLICY_FIFO, 4'd0, 4'd0);
        push_item(sacl_pkg::OP_ACCESS, 32'h1234_567C);
        drain_results();
        apply_config(sacl_pkg::POLICY_LRU, 4'd0, 4'd3);
        push_item(sacl_pkg::OP_ACCESS, 32'h1234_5671);
        push_item(sacl_pkg::OP_ACCESS, 32'h8000_0004);
        drain_results();
    endtask

    // Index bits and ways above their maximum are clamped.
    task automatic test_config_clamps();
        apply_config(sacl_pkg::POLICY_LRU, 4'd15, 4'd15);
        push_item(sacl_pkg::OP_ACCESS, 32'hFFFF_FFF0);
        push_item(sacl_pkg::OP_ACCESS, 32'h0000_03F0);
        push_item(sacl_pkg::OP_CLEAR,  32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic hold_receiver(input int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx <= 1'b0;
    endtask

    // The output stalls long enough that the cache has to stop taking items.
    task automatic test_full_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(sacl_pkg::POLICY_LRU, 4'd2, 4'd8);
        setup_hot_lines();
        fork
            hold_receiver(400);
            for (int i = 0; i < 48; i++)
                push_item(sacl_pkg::OP_ACCESS, hot_address());
        join
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic                  pol_tab  [12] = '{
            sacl_pkg::POLICY_LRU, sacl_pkg::POLICY_FIFO, sacl_pkg::POLICY_LRU,
            sacl_pkg::POLICY_FIFO, sacl_pkg::POLICY_LRU, sacl_pkg::POLICY_FIFO,
            sacl_pkg::POLICY_LRU, sacl_pkg::POLICY_FIFO, sacl_pkg::POLICY_LRU,
            sacl_pkg::POLICY_FIFO, sacl_pkg::POLICY_LRU, sacl_pkg::POLICY_FIFO};
        logic [CFG_DATA_W-1:0] bits_tab [12] = '{4'd10, 4'd0, 4'd0, 4'd3, 4'd15, 4'd10,
                                                 4'd2, 4'd1, 4'd4, 4'd6, 4'd8, 4'd12};
        logic [CFG_DATA_W-1:0] ways_tab [12] = '{4'd8, 4'd8, 4'd1, 4'd4, 4'd8, 4'd1,
                                                 4'd15, 4'd0, 4'd2, 4'd5, 4'd3, 4'd7};
        logic                  pol;
        logic [CFG_DATA_W-1:0] bits;
        logic [CFG_DATA_W-1:0] ways;
        int unsigned           roll;
        for (int p = 0; p < 14; p++)
        begin
            case (p * 3 / 14)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p < 12)
            begin
                pol  = pol_tab[p];
                bits = bits_tab[p];
                ways = ways_tab[p];
            end
            else
            begin
                pol  = 1'($urandom_range(0, 1));
                bits = CFG_DATA_W'($urandom_range(0, 15));
                ways = CFG_DATA_W'($urandom_range(0, 15));
            end
            apply_config(pol, bits, ways);
            setup_hot_lines();
            // Half the phases start on whatever the previous setting left behind.
            if ($urandom_range(0, 1))
                push_item(sacl_pkg::OP_CLEAR, $urandom());
            repeat (114)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    push_item(sacl_pkg::OP_CLEAR, $urandom());
                else if (roll < 20)
                    push_item(sacl_pkg::OP_ACCESS, $urandom());
                else
                    push_item(sacl_pkg::OP_ACCESS, hot_address());
            end
            drain_results();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_replacement_order();
        test_stale_ways();
        test_config_clamps();
        test_random_traffic();
        test_full_backpressure();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
